FILE: hw/rtl/ckst_pkg.sv
// shared types, constants and helpers for the color key span tracker
// no dependencies; used by ckst_span, ckst_result and the top level
package ckst_pkg;

    localparam int unsigned COL_W       = 9;
    localparam int unsigned STRIP_WIDTH = 512;
    localparam int unsigned STRIP_CMP_W = 13;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned DIST_W      = 10;
    localparam int unsigned OFFSET_W    = 10;
    localparam int unsigned MARGIN_W    = 8;
    localparam int unsigned LIMIT_W     = 4;
    localparam int unsigned POS_W       = 11;
    localparam int unsigned MISS_W      = 5;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned DATA_W      = 32;

    localparam logic [MISS_W-1:0]   MISS_MAX = '1;
    localparam logic [COL_W-1:0]    FIRST_RESET = '1;
    localparam logic [COL_W-1:0]    LAST_RESET  = '0;

    localparam logic [COLOR_W-1:0]  BAND_COLOR_RESET     = 24'd11389482;
    localparam logic [COLOR_W-1:0]  CURSOR_COLOR_RESET   = 24'd10352382;
    localparam logic [DIST_W-1:0]   DISTANCE_LIMIT_RESET = 10'd80;
    localparam logic [OFFSET_W-1:0] COLUMN_OFFSET_RESET  = 10'd412;
    localparam logic [MARGIN_W-1:0] STEER_MARGIN_RESET   = 8'd2;
    localparam logic [LIMIT_W-1:0]  MISS_LIMIT_RESET     = 4'd10;

    // floor(x / 3) by reciprocal, exact for x below 2048
    localparam logic [19:0] DIV3_MUL   = 20'd683;
    localparam int unsigned DIV3_SHIFT = 11;

    typedef enum logic [2:0] {
        REG_BAND_COLOR     = 3'd0,
        REG_CURSOR_COLOR   = 3'd1,
        REG_DISTANCE_LIMIT = 3'd2,
        REG_COLUMN_OFFSET  = 3'd3,
        REG_STEER_MARGIN   = 3'd4,
        REG_MISS_LIMIT     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        STEER_NONE    = 2'd0,
        STEER_RIGHT   = 2'd1,
        STEER_LEFT    = 2'd2,
        STEER_RELEASE = 2'd3
    } t_steer;

    typedef struct packed {
        logic [COLOR_W-1:0]  band_color;
        logic [COLOR_W-1:0]  cursor_color;
        logic [DIST_W-1:0]   distance_limit;
        logic [OFFSET_W-1:0] column_offset;
        logic [MARGIN_W-1:0] steer_margin;
        logic [LIMIT_W-1:0]  miss_limit;
    } t_cfg;

    typedef struct packed {
        logic             band_seen;
        logic [COL_W-1:0] band_first;
        logic [COL_W-1:0] band_last;
        logic             cursor_seen;
        logic [COL_W-1:0] cursor_first;
        logic [COL_W-1:0] cursor_last;
    } t_frame_span;

    localparam t_frame_span SPAN_CLEAR = '{
        band_seen:    1'b0,
        band_first:   FIRST_RESET,
        band_last:    LAST_RESET,
        cursor_seen:  1'b0,
        cursor_first: FIRST_RESET,
        cursor_last:  LAST_RESET
    };

    function automatic logic [COL_W-1:0] div3(input logic [COL_W:0] x);
        logic [19:0] prod;
        prod = 20'(x) * DIV3_MUL;
        return prod[DIV3_SHIFT +: COL_W];
    endfunction

endpackage

FILE: hw/rtl/ckst_span.sv
// pixel input register, key color matching and per-frame span tracking
// depends on ckst_pkg; hands a frame span snapshot to ckst_result
module ckst_span (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ckst_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ckst_pkg::CHAN_W-1:0] i_blue,
    input  logic [ckst_pkg::CHAN_W-1:0] i_green,
    input  logic [ckst_pkg::CHAN_W-1:0] i_red,
    input  logic [ckst_pkg::COL_W-1:0]  i_column,
    input  logic                        i_frame_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ckst_pkg::t_frame_span       o_span
);

    function automatic logic [ckst_pkg::CHAN_W-1:0] absdiff(
        input logic [ckst_pkg::CHAN_W-1:0] a,
        input logic [ckst_pkg::CHAN_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [ckst_pkg::DIST_W-1:0] key_dist(
        input logic [ckst_pkg::COLOR_W-1:0] key,
        input logic [ckst_pkg::CHAN_W-1:0]  b,
        input logic [ckst_pkg::CHAN_W-1:0]  g,
        input logic [ckst_pkg::CHAN_W-1:0]  r
    );
        return ckst_pkg::DIST_W'(absdiff(b, key[23:16]))
             + ckst_pkg::DIST_W'(absdiff(g, key[15:8]))
             + ckst_pkg::DIST_W'(absdiff(r, key[7:0]));
    endfunction

    logic                        r_s1_v;
    logic [ckst_pkg::CHAN_W-1:0] r_blue;
    logic [ckst_pkg::CHAN_W-1:0] r_green;
    logic [ckst_pkg::CHAN_W-1:0] r_red;
    logic [ckst_pkg::COL_W-1:0]  r_col;
    logic                        r_fend;

    ckst_pkg::t_frame_span r_span;
    ckst_pkg::t_frame_span n_span;
    ckst_pkg::t_frame_span r_snap;
    logic                  r_snap_v;

    logic in_strip;
    logic band_hit;
    logic cursor_hit;
    logic s1_go;
    logic accept;

    assign s1_go   = r_s1_v && (!r_fend || !r_snap_v || i_ready);
    assign o_ready = !r_s1_v || s1_go;
    assign accept  = i_valid && o_ready;

    assign in_strip = ckst_pkg::STRIP_CMP_W'(r_col)
                    < ckst_pkg::STRIP_CMP_W'(ckst_pkg::STRIP_WIDTH);
    assign band_hit = r_s1_v && in_strip
        && (key_dist(i_cfg.band_color, r_blue, r_green, r_red) < i_cfg.distance_limit);
    assign cursor_hit = r_s1_v && in_strip
        && (key_dist(i_cfg.cursor_color, r_blue, r_green, r_red) < i_cfg.distance_limit);

    // span including the pixel now in the input register
    always_comb begin
        n_span = r_span;
        if (band_hit) begin
            n_span.band_seen = 1'b1;
            if (r_col < r_span.band_first) n_span.band_first = r_col;
            if (r_col > r_span.band_last)  n_span.band_last  = r_col;
        end
        if (cursor_hit) begin
            n_span.cursor_seen = 1'b1;
            if (r_col < r_span.cursor_first) n_span.cursor_first = r_col;
            if (r_col > r_span.cursor_last)  n_span.cursor_last  = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
        if (accept) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_col   <= i_column;
            r_fend  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span   <= ckst_pkg::SPAN_CLEAR;
            r_snap_v <= 1'b0;
        end else begin
            if (s1_go) begin
                r_span <= r_fend ? ckst_pkg::SPAN_CLEAR : n_span;
            end
            r_snap_v <= (r_snap_v && !i_ready) || (s1_go && r_fend);
        end
        if (s1_go && r_fend) begin
            r_snap <= n_span;
        end
    end

    assign o_valid = r_snap_v;
    assign o_span  = r_snap;

endmodule

FILE: hw/rtl/ckst_result.sv
// frame result: band window, cursor center, steer code and missed-frame count
// depends on ckst_pkg; fed by the frame span snapshot from ckst_span
module ckst_result (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ckst_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  ckst_pkg::t_frame_span      i_span,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_band_found,
    output logic [ckst_pkg::POS_W-1:0] o_band_low,
    output logic [ckst_pkg::POS_W-1:0] o_band_high,
    output logic                       o_cursor_found,
    output logic [ckst_pkg::POS_W-1:0] o_cursor_pos,
    output logic [1:0]                 o_steer,
    output logic                       o_give_up
);

    localparam int unsigned CMP_W = ckst_pkg::POS_W + 1;

    logic [ckst_pkg::COL_W-1:0]  band_span;
    logic [ckst_pkg::POS_W-1:0]  band_base;
    logic [ckst_pkg::COL_W:0]    cursor_sum;
    logic [ckst_pkg::POS_W-1:0]  n_blow;
    logic [ckst_pkg::POS_W-1:0]  n_bhigh;
    logic [ckst_pkg::POS_W-1:0]  n_cpos;

    logic                        r_pos_v;
    logic                        r_bfound;
    logic [ckst_pkg::POS_W-1:0]  r_blow;
    logic [ckst_pkg::POS_W-1:0]  r_bhigh;
    logic                        r_cfound;
    logic [ckst_pkg::POS_W-1:0]  r_cpos;

    logic                        both_found;
    logic [CMP_W-1:0]            low_edge;
    logic [CMP_W-1:0]            cursor_edge;
    ckst_pkg::t_steer            n_steer;
    logic [ckst_pkg::MISS_W-1:0] n_miss;

    logic                        r_out_v;
    logic                        r_bfound_o;
    logic [ckst_pkg::POS_W-1:0]  r_blow_o;
    logic [ckst_pkg::POS_W-1:0]  r_bhigh_o;
    logic                        r_cfound_o;
    logic [ckst_pkg::POS_W-1:0]  r_cpos_o;
    ckst_pkg::t_steer            r_steer;
    logic                        r_give_up;
    logic [ckst_pkg::MISS_W-1:0] r_miss;

    logic out_free;
    logic pos_go;

    assign out_free = !r_out_v || i_ready;
    assign pos_go   = r_pos_v && out_free;
    assign o_ready  = !r_pos_v || out_free;

    // positions never pass 2047 with 9-bit columns and a 10-bit offset
    assign band_span  = i_span.band_last - i_span.band_first;
    assign band_base  = ckst_pkg::POS_W'(i_span.band_first)
                      + ckst_pkg::POS_W'(i_cfg.column_offset);
    assign cursor_sum = {1'b0, i_span.cursor_first} + {1'b0, i_span.cursor_last};

    always_comb begin
        n_blow  = '0;
        n_bhigh = '0;
        n_cpos  = '0;
        if (i_span.band_seen) begin
            n_blow  = band_base + ckst_pkg::POS_W'(ckst_pkg::div3({1'b0, band_span}));
            n_bhigh = band_base + ckst_pkg::POS_W'(ckst_pkg::div3({band_span, 1'b0}));
        end
        if (i_span.cursor_seen) begin
            n_cpos = ckst_pkg::POS_W'(cursor_sum[ckst_pkg::COL_W:1])
                   + ckst_pkg::POS_W'(i_cfg.column_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_v <= 1'b0;
        end else begin
            r_pos_v <= (r_pos_v && !out_free) || (i_valid && o_ready);
        end
        if (i_valid && o_ready) begin
            r_bfound <= i_span.band_seen;
            r_blow   <= n_blow;
            r_bhigh  <= n_bhigh;
            r_cfound <= i_span.cursor_seen;
            r_cpos   <= n_cpos;
        end
    end

    assign both_found  = r_bfound && r_cfound;
    assign low_edge    = CMP_W'(r_blow) + CMP_W'(i_cfg.steer_margin);
    assign cursor_edge = CMP_W'(r_cpos) + CMP_W'(i_cfg.steer_margin);

    always_comb begin
        n_steer = ckst_pkg::STEER_NONE;
        if (both_found) begin
            if (CMP_W'(r_cpos) < low_edge) begin
                n_steer = ckst_pkg::STEER_RIGHT;
            end else if (cursor_edge > CMP_W'(r_bhigh)) begin
                n_steer = ckst_pkg::STEER_LEFT;
            end else begin
                n_steer = ckst_pkg::STEER_RELEASE;
            end
        end
    end

    always_comb begin
        if (both_found) begin
            n_miss = '0;
        end else if (r_miss == ckst_pkg::MISS_MAX) begin
            n_miss = r_miss;
        end else begin
            n_miss = r_miss + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_miss  <= '0;
        end else begin
            r_out_v <= (r_out_v && !i_ready) || pos_go;
            if (pos_go) begin
                r_miss <= n_miss;
            end
        end
        if (pos_go) begin
            r_bfound_o <= r_bfound;
            r_blow_o   <= r_blow;
            r_bhigh_o  <= r_bhigh;
            r_cfound_o <= r_cfound;
            r_cpos_o   <= r_cpos;
            r_steer    <= n_steer;
            r_give_up  <= n_miss > ckst_pkg::MISS_W'(i_cfg.miss_limit);
        end
    end

    assign o_valid        = r_out_v;
    assign o_band_found   = r_bfound_o;
    assign o_band_low     = r_blow_o;
    assign o_band_high    = r_bhigh_o;
    assign o_cursor_found = r_cfound_o;
    assign o_cursor_pos   = r_cpos_o;
    assign o_steer        = r_steer;
    assign o_give_up      = r_give_up;

    a_steer_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_steer != ckst_pkg::STEER_NONE) |-> r_bfound_o && r_cfound_o)
        else $error("steer code set on a missed frame");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_bfound_o |-> r_blow_o <= r_bhigh_o)
        else $error("band window low edge above high edge");

    a_unseen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_bfound_o |-> (r_blow_o == '0) && (r_bhigh_o == '0))
        else $error("band window nonzero without band pixels");

    a_found_clears_give_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos_go && both_found |=> (r_miss == '0) && !r_give_up)
        else $error("found frame did not clear miss count");

endmodule

FILE: hw/rtl/color_key_span_tracker_top.sv
// top level of the color key span tracker: config registers and the two stages
// depends on ckst_pkg, ckst_span and ckst_result
//
// One pixel is accepted per clock when the output side keeps up; the span
// min/max update is combinational on the input register, which sets that
// rate. The frame result passes the input register, span snapshot, position
// stage and output register after its frame_end pixel is accepted. Pixels
// without frame_end give no result. Registers sit at byte addresses 4*i:
// band_color, cursor_color, distance_limit, column_offset, steer_margin,
// miss_limit; change them only while no frame is in flight.
module color_key_span_tracker_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckst_pkg::ADDR_W-1:0] paddr,
    input  logic [ckst_pkg::DATA_W-1:0] pwdata,
    output logic [ckst_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ckst_pkg::CHAN_W-1:0] i_blue,
    input  logic [ckst_pkg::CHAN_W-1:0] i_green,
    input  logic [ckst_pkg::CHAN_W-1:0] i_red,
    input  logic [ckst_pkg::COL_W-1:0]  i_column,
    input  logic                        i_frame_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_band_found,
    output logic [ckst_pkg::POS_W-1:0]  o_band_low,
    output logic [ckst_pkg::POS_W-1:0]  o_band_high,
    output logic                        o_cursor_found,
    output logic [ckst_pkg::POS_W-1:0]  o_cursor_pos,
    output logic [1:0]                  o_steer,
    output logic                        o_give_up
);

    ckst_pkg::t_cfg        r_cfg;
    ckst_pkg::t_reg_idx    reg_idx;
    ckst_pkg::t_frame_span span;
    logic                  span_valid;
    logic                  span_ready;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = ckst_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_color     <= ckst_pkg::BAND_COLOR_RESET;
            r_cfg.cursor_color   <= ckst_pkg::CURSOR_COLOR_RESET;
            r_cfg.distance_limit <= ckst_pkg::DISTANCE_LIMIT_RESET;
            r_cfg.column_offset  <= ckst_pkg::COLUMN_OFFSET_RESET;
            r_cfg.steer_margin   <= ckst_pkg::STEER_MARGIN_RESET;
            r_cfg.miss_limit     <= ckst_pkg::MISS_LIMIT_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                ckst_pkg::REG_BAND_COLOR: begin
                    r_cfg.band_color <= pwdata[ckst_pkg::COLOR_W-1:0];
                end
                ckst_pkg::REG_CURSOR_COLOR: begin
                    r_cfg.cursor_color <= pwdata[ckst_pkg::COLOR_W-1:0];
                end
                ckst_pkg::REG_DISTANCE_LIMIT: begin
                    r_cfg.distance_limit <= pwdata[ckst_pkg::DIST_W-1:0];
                end
                ckst_pkg::REG_COLUMN_OFFSET: begin
                    r_cfg.column_offset <= pwdata[ckst_pkg::OFFSET_W-1:0];
                end
                ckst_pkg::REG_STEER_MARGIN: begin
                    r_cfg.steer_margin <= pwdata[ckst_pkg::MARGIN_W-1:0];
                end
                ckst_pkg::REG_MISS_LIMIT: begin
                    r_cfg.miss_limit <= pwdata[ckst_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ckst_pkg::REG_BAND_COLOR:     prdata = ckst_pkg::DATA_W'(r_cfg.band_color);
            ckst_pkg::REG_CURSOR_COLOR:   prdata = ckst_pkg::DATA_W'(r_cfg.cursor_color);
            ckst_pkg::REG_DISTANCE_LIMIT: prdata = ckst_pkg::DATA_W'(r_cfg.distance_limit);
            ckst_pkg::REG_COLUMN_OFFSET:  prdata = ckst_pkg::DATA_W'(r_cfg.column_offset);
            ckst_pkg::REG_STEER_MARGIN:   prdata = ckst_pkg::DATA_W'(r_cfg.steer_margin);
            ckst_pkg::REG_MISS_LIMIT:     prdata = ckst_pkg::DATA_W'(r_cfg.miss_limit);
            default:                      prdata = '0;
        endcase
    end

    ckst_span u_span (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_column    (i_column),
        .i_frame_end (i_frame_end),
        .o_valid     (span_valid),
        .i_ready     (span_ready),
        .o_span      (span)
    );

    ckst_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (span_valid),
        .o_ready        (span_ready),
        .i_span         (span),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_band_found   (o_band_found),
        .o_band_low     (o_band_low),
        .o_band_high    (o_band_high),
        .o_cursor_found (o_cursor_found),
        .o_cursor_pos   (o_cursor_pos),
        .o_steer        (o_steer),
        .o_give_up      (o_give_up)
    );

endmodule
